/* rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
// no dependencies; each macro compiles away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SQM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define SQM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SQM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SQM_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/sqm_pkg.sv */
// shared constants, codes and command type of the sorted queue merge block
// no dependencies
`default_nettype none

package sqm_pkg;

    // queue sizing
    localparam int QUEUE_CAPACITY = 16;
    localparam int IDX_W          = $clog2(QUEUE_CAPACITY);
    localparam int CNT_W          = $clog2(QUEUE_CAPACITY + 1);
    localparam int SUM_W          = CNT_W + 1;

    // command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int DATA_W = 32;

    // operation codes
    localparam logic [1:0] OP_PUSH_A = 2'd0;
    localparam logic [1:0] OP_PUSH_B = 2'd1;
    localparam logic [1:0] OP_MERGE  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_PUSH_OK   = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL = 2'd1;
    localparam logic [1:0] ST_MERGED    = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // one classified request handed from front to back
    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/sorted_queue_merge.sv */
// sorted_queue_merge: two fifo queues of signed values merged into one sorted stream
// depends on sqm_pkg, sqm_front and sqm_back
//
// usage:
//   request channel: operation and value are taken at a clock edge where start is
//   high and busy is low. operation 0 pushes value to queue a, 1 pushes to queue b,
//   2 merges and drains both queues, 3 is taken and ignored with no result.
//   result channel: strobe marks one result for exactly one cycle with status,
//   element, from_queue and last; the receiver cannot stall it.
// results and flow:
//   a push gives its one result through the command queue and the result registers,
//   and pushes are taken one per cycle while busy is low. a merge of n held entries
//   streams n results on consecutive cycles, after the command queue and the merge
//   state, last on the final one; with both queues empty it gives one nothing-to-merge
//   result. the back end executes one command at a time, so during a merge the
//   two-entry command queue can fill and busy rises until the merge finishes.
// reset:
//   rst_n clears both queues, the command queue and the result strobe; queue
//   contents themselves are not cleared and are only read once written.
`default_nettype none

module sorted_queue_merge (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [1:0]                        operation,
    input  wire logic signed [sqm_pkg::DATA_W-1:0] value,
    output logic                                   busy,
    output logic                                   strobe,
    output logic [1:0]                             status,
    output logic signed [sqm_pkg::DATA_W-1:0]      element,
    output logic                                   from_queue,
    output logic                                   last
);

    sqm_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    // request intake and command queue
    sqm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .value     (value),
        .busy      (busy),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // queue storage, merge engine and result registers
    sqm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .strobe     (strobe),
        .status     (status),
        .element    (element),
        .from_queue (from_queue),
        .last       (last)
    );

endmodule

`default_nettype wire

/* rtl/sqm_front.sv */
// front part: accepts requests, drops undefined operations, queues commands
// depends on sqm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sqm_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [1:0]                        operation,
    input  wire logic signed [sqm_pkg::DATA_W-1:0] value,
    output logic                                   busy,
    output sqm_pkg::cmd_t                          cmd,
    output logic                                   cmd_valid,
    input  wire logic                              cmd_pop
);

    sqm_pkg::cmd_t                   cmd_mem_reg [sqm_pkg::CMD_DEPTH];
    logic [sqm_pkg::CMD_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [sqm_pkg::CMD_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [sqm_pkg::CMD_CNT_W-1:0]   count_reg, count_next;
    logic                            accept;
    logic                            op_known;
    logic                            enq;
    logic                            deq;

    // classify: only pushes and merges become commands
    assign op_known = (operation == sqm_pkg::OP_PUSH_A) ||
                      (operation == sqm_pkg::OP_PUSH_B) ||
                      (operation == sqm_pkg::OP_MERGE);

    assign busy      = (count_reg == sqm_pkg::CMD_CNT_W'(sqm_pkg::CMD_DEPTH));
    assign accept    = start && !busy;
    assign enq       = accept && op_known;
    assign cmd_valid = (count_reg != '0);
    assign deq       = cmd_pop && cmd_valid;
    assign cmd       = cmd_mem_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == sqm_pkg::CMD_PTR_W'(sqm_pkg::CMD_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == sqm_pkg::CMD_PTR_W'(sqm_pkg::CMD_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({enq, deq})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            cmd_mem_reg[wr_ptr_reg] <= '{op: operation, value: value};
        end
    end

    // checks
    `SQM_NEVER(a_cnt_range, clk, rst_n,
        count_reg > sqm_pkg::CMD_CNT_W'(sqm_pkg::CMD_DEPTH), "command queue overfilled")
    `SQM_ASSERT(a_cnt_track, clk, rst_n,
        (enq && !deq) |=> (count_reg == $past(count_reg) + 1'b1), "enqueue not counted")
    `SQM_ASSERT(a_ptr_match, clk, rst_n,
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "pointers apart while empty")

endmodule

`default_nettype wire

/* rtl/sqm_back.sv */
// back part: holds queues a and b, executes pushes and merges, drives results
// depends on sqm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sqm_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sqm_pkg::cmd_t                     cmd,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_pop,
    output logic                                   strobe,
    output logic [1:0]                             status,
    output logic signed [sqm_pkg::DATA_W-1:0]      element,
    output logic                                   from_queue,
    output logic                                   last
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_MERGE = 1'b1;

    localparam logic [sqm_pkg::CNT_W-1:0] CAP_CNT = sqm_pkg::CNT_W'(sqm_pkg::QUEUE_CAPACITY);
    localparam logic [sqm_pkg::SUM_W-1:0] CAP_SUM = sqm_pkg::SUM_W'(sqm_pkg::QUEUE_CAPACITY);
    localparam logic [sqm_pkg::IDX_W-1:0] IDX_MAX =
        sqm_pkg::IDX_W'(sqm_pkg::QUEUE_CAPACITY - 1);

    logic signed [sqm_pkg::DATA_W-1:0] store_a_reg [sqm_pkg::QUEUE_CAPACITY];
    logic signed [sqm_pkg::DATA_W-1:0] store_b_reg [sqm_pkg::QUEUE_CAPACITY];

    logic                        state_reg, state_next;
    logic [sqm_pkg::IDX_W-1:0]   head_a_reg, head_a_next, head_b_reg, head_b_next;
    logic [sqm_pkg::CNT_W-1:0]   count_a_reg, count_a_next, count_b_reg, count_b_next;

    logic                              strobe_reg, strobe_next;
    logic [1:0]                        status_reg, status_next;
    logic signed [sqm_pkg::DATA_W-1:0] element_reg, element_next;
    logic                              from_reg, from_next;
    logic                              last_reg, last_next;

    logic signed [sqm_pkg::DATA_W-1:0] head_val_a, head_val_b;
    logic [sqm_pkg::SUM_W-1:0]         sum_a, sum_b;
    logic [sqm_pkg::IDX_W-1:0]         tail_a, tail_b;
    logic                              take_a;
    logic                              drain_done;
    logic                              wr_a, wr_b;

    // heads of both queues
    assign head_val_a = store_a_reg[head_a_reg];
    assign head_val_b = store_b_reg[head_b_reg];

    // tail slot: head plus count, wrapped once
    assign sum_a  = sqm_pkg::SUM_W'(head_a_reg) + sqm_pkg::SUM_W'(count_a_reg);
    assign sum_b  = sqm_pkg::SUM_W'(head_b_reg) + sqm_pkg::SUM_W'(count_b_reg);
    assign tail_a = (sum_a >= CAP_SUM) ? sqm_pkg::IDX_W'(sum_a - CAP_SUM)
                                       : sqm_pkg::IDX_W'(sum_a);
    assign tail_b = (sum_b >= CAP_SUM) ? sqm_pkg::IDX_W'(sum_b - CAP_SUM)
                                       : sqm_pkg::IDX_W'(sum_b);

    // merge choice: a wins when b is empty or its head is strictly smaller, ties go to b
    assign take_a = (count_a_reg != '0) &&
                    ((count_b_reg == '0) || (head_val_a < head_val_b));
    assign drain_done = take_a ? ((count_a_reg == 1) && (count_b_reg == '0))
                               : ((count_b_reg == 1) && (count_a_reg == '0));

    // command execution
    always_comb
    begin
        state_next   = state_reg;
        head_a_next  = head_a_reg;
        head_b_next  = head_b_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        strobe_next  = 1'b0;
        status_next  = sqm_pkg::ST_PUSH_OK;
        element_next = '0;
        from_next    = 1'b0;
        last_next    = 1'b0;
        cmd_pop      = 1'b0;
        wr_a         = 1'b0;
        wr_b         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        sqm_pkg::OP_PUSH_A:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            from_next   = 1'b0;
                            if (count_a_reg == CAP_CNT)
                            begin
                                status_next = sqm_pkg::ST_PUSH_FULL;
                            end
                            else
                            begin
                                wr_a         = 1'b1;
                                count_a_next = count_a_reg + 1'b1;
                            end
                        end
                        sqm_pkg::OP_PUSH_B:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            from_next   = 1'b1;
                            if (count_b_reg == CAP_CNT)
                            begin
                                status_next = sqm_pkg::ST_PUSH_FULL;
                            end
                            else
                            begin
                                wr_b         = 1'b1;
                                count_b_next = count_b_reg + 1'b1;
                            end
                        end
                        sqm_pkg::OP_MERGE:
                        begin
                            if ((count_a_reg == '0) && (count_b_reg == '0))
                            begin
                                strobe_next = 1'b1;
                                status_next = sqm_pkg::ST_EMPTY;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MERGE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MERGE:
            begin
                strobe_next = 1'b1;
                status_next = sqm_pkg::ST_MERGED;
                last_next   = drain_done;
                if (take_a)
                begin
                    element_next = head_val_a;
                    from_next    = 1'b0;
                    head_a_next  = (head_a_reg == IDX_MAX) ? '0 : head_a_reg + 1'b1;
                    count_a_next = count_a_reg - 1'b1;
                end
                else
                begin
                    element_next = head_val_b;
                    from_next    = 1'b1;
                    head_b_next  = (head_b_reg == IDX_MAX) ? '0 : head_b_reg + 1'b1;
                    count_b_next = count_b_reg - 1'b1;
                end
                if (drain_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_a_reg  <= '0;
            head_b_reg  <= '0;
            count_a_reg <= '0;
            count_b_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_a_reg  <= head_a_next;
            head_b_reg  <= head_b_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            strobe_reg  <= strobe_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        from_reg    <= from_next;
        last_reg    <= last_next;
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            store_a_reg[tail_a] <= cmd.value;
        end
        if (wr_b)
        begin
            store_b_reg[tail_b] <= cmd.value;
        end
    end

    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign element    = element_reg;
    assign from_queue = from_reg;
    assign last       = last_reg;

    // checks
    `SQM_NEVER(a_cnt_a_range, clk, rst_n, count_a_reg > CAP_CNT, "queue a overfilled")
    `SQM_NEVER(a_cnt_b_range, clk, rst_n, count_b_reg > CAP_CNT, "queue b overfilled")
    `SQM_ASSERT(a_merge_nonempty, clk, rst_n,
        (state_reg == S_MERGE) |-> ((count_a_reg != '0) || (count_b_reg != '0)),
        "merging with both queues empty")
    `SQM_ASSERT(a_last_ends_merge, clk, rst_n,
        (strobe_reg && (status_reg == sqm_pkg::ST_MERGED) && last_reg) |->
        ((state_reg == S_IDLE) && (count_a_reg == '0) && (count_b_reg == '0)),
        "final merged result left data behind")
    `SQM_ASSERT(a_mid_merge, clk, rst_n,
        (strobe_reg && (status_reg == sqm_pkg::ST_MERGED) && !last_reg) |->
        (state_reg == S_MERGE), "merge stopped before final result")

endmodule

`default_nettype wire

/* tb/sorted_queue_merge_tb.sv */
// self-checking testbench for sorted_queue_merge: push and merge requests with random gaps
// depends on sqm_pkg and the sorted_queue_merge rtl; results checked by a scoreboard class
`timescale 1ns / 1ps

// one result as the block presents it
typedef struct packed {
    logic [1:0]                       status;
    logic signed [sqm_pkg::DATA_W-1:0] element;
    logic                             from_queue;
    logic                             last;
} merge_result_t;

class sqm_scoreboard;

    // shadow copies of both queues, oldest entry first
    logic signed [sqm_pkg::DATA_W-1:0] shadow_a[$];
    logic signed [sqm_pkg::DATA_W-1:0] shadow_b[$];
    merge_result_t expected_results[$];
    int failures;

    function new();
        failures = 0;
    endfunction

    function void add_expected(logic [1:0] st, logic signed [sqm_pkg::DATA_W-1:0] elem,
                               logic src, logic lst);
        merge_result_t res;
        res.status     = st;
        res.element    = elem;
        res.from_queue = src;
        res.last       = lst;
        expected_results.push_back(res);
    endfunction

    // work out the results of one accepted request and update the shadow queues
    function void note_request(logic [1:0] op, logic signed [sqm_pkg::DATA_W-1:0] val);
        logic                             full;
        logic                             take_a;
        logic signed [sqm_pkg::DATA_W-1:0] elem;
        if (op == sqm_pkg::OP_PUSH_A || op == sqm_pkg::OP_PUSH_B)
        begin
            full = (op == sqm_pkg::OP_PUSH_A) ? (shadow_a.size() >= sqm_pkg::QUEUE_CAPACITY)
                                              : (shadow_b.size() >= sqm_pkg::QUEUE_CAPACITY);
            if (!full)
            begin
                if (op == sqm_pkg::OP_PUSH_A)
                    shadow_a.push_back(val);
                else
                    shadow_b.push_back(val);
            end
            add_expected(full ? sqm_pkg::ST_PUSH_FULL : sqm_pkg::ST_PUSH_OK, '0, op[0], 1'b1);
        end
        else if (op == sqm_pkg::OP_MERGE)
        begin
            if (shadow_a.size() == 0 && shadow_b.size() == 0)
                add_expected(sqm_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
            // drain in order, ties go to queue b
            while (shadow_a.size() != 0 || shadow_b.size() != 0)
            begin
                take_a = (shadow_b.size() == 0) ||
                         (shadow_a.size() != 0 && shadow_a[0] < shadow_b[0]);
                if (take_a)
                    elem = shadow_a.pop_front();
                else
                    elem = shadow_b.pop_front();
                add_expected(sqm_pkg::ST_MERGED, elem, !take_a,
                             shadow_a.size() == 0 && shadow_b.size() == 0);
            end
        end
        // the unused operation code changes nothing and gives no result
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [1:0] st, logic signed [sqm_pkg::DATA_W-1:0] elem,
                               logic src, logic lst);
        merge_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: status %0d element %0d from_queue %0d last %0d",
                   st, elem, src, lst);
            failures++;
            return;
        end
        want = expected_results.pop_front();
        if (st !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, st);
            failures++;
        end
        if (elem !== want.element)
        begin
            $error("element: expected %0d, actual %0d", want.element, elem);
            failures++;
        end
        if (src !== want.from_queue)
        begin
            $error("from_queue: expected %0d, actual %0d", want.from_queue, src);
            failures++;
        end
        if (lst !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, lst);
            failures++;
        end
    endfunction

endclass

module sorted_queue_merge_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 400;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 8;
    localparam logic signed [sqm_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [sqm_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic [1:0]                        operation = sqm_pkg::OP_PUSH_A;
    logic signed [sqm_pkg::DATA_W-1:0] value = '0;
    logic                              busy;
    logic                              strobe;
    logic [1:0]                        status;
    logic signed [sqm_pkg::DATA_W-1:0] element;
    logic                              from_queue;
    logic                              last;

    sqm_scoreboard sb;
    int            requests_sent = 0;
    int            cycle_count = 0;
    bit            idling = 1'b1;

    sorted_queue_merge DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .value      (value),
        .busy       (busy),
        .strobe     (strobe),
        .status     (status),
        .element    (element),
        .from_queue (from_queue),
        .last       (last)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // every strobed result is checked at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(status, element, from_queue, last);
    end

    // hold one request until accepted, then maybe leave a gap
    task automatic issue_request(input logic [1:0] op,
                                 input logic signed [sqm_pkg::DATA_W-1:0] val);
        int pick;
        int gap;
        start     <= 1'b1;
        operation <= op;
        value     <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(op, val);
        if (op != OP_UNUSED)
            requests_sent++;
        pick = $urandom_range(0, 99);
        if (!idling || pick < 60)
            gap = 0;
        else if (pick < 88)
            gap = $urandom_range(1, 3);
        else if (pick < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            start     <= 1'b0;
            operation <= 2'($urandom_range(0, 3));
            value     <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending until every expected result has come out
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // next value of an ascending run, saturated at the top of the range
    function automatic longint next_sorted(longint cur, bit narrow);
        longint nxt;
        nxt = cur + (narrow ? $urandom_range(0, 2) : $urandom_range(0, 32'h0800_0000));
        if (nxt > longint'(VAL_MAX))
            nxt = longint'(VAL_MAX);
        return nxt;
    endfunction

    initial
    begin
        int     goal;
        int     kind;
        int     mode;
        int     left_a;
        int     left_b;
        bit     narrow;
        longint cur_a;
        longint cur_b;

        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty merge, unused code, full queue a, ties at both ends
        issue_request(sqm_pkg::OP_MERGE, '0);
        issue_request(OP_UNUSED, 32'sh5A5A_A5A5);
        for (int i = 0; i < sqm_pkg::QUEUE_CAPACITY; i++)
            issue_request(sqm_pkg::OP_PUSH_A, (i == 0) ? VAL_MIN :
                          (i == sqm_pkg::QUEUE_CAPACITY - 1) ? VAL_MAX :
                          (i - 8) * 32'sh0888_8888);
        issue_request(sqm_pkg::OP_PUSH_A, 32'sd1);
        issue_request(sqm_pkg::OP_PUSH_B, VAL_MIN);
        issue_request(sqm_pkg::OP_PUSH_B, '0);
        issue_request(sqm_pkg::OP_PUSH_B, VAL_MAX);
        issue_request(sqm_pkg::OP_MERGE, '1);
        wait_drained();

        // random: mostly sorted runs into both queues followed by a merge
        goal = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < goal)
        begin
            idling = ($urandom_range(0, 3) != 0);
            kind   = $urandom_range(0, 99);
            if (kind < 75)
            begin
                left_a = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18)
                                                     : $urandom_range(0, 8);
                left_b = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18)
                                                     : $urandom_range(0, 8);
                mode   = $urandom_range(0, 3);
                narrow = (mode == 2);
                case (mode)
                    0:       cur_a = longint'(VAL_MIN);
                    2:       cur_a = longint'($urandom_range(0, 8)) - 4;
                    default: cur_a = longint'($signed($urandom));
                endcase
                cur_b = (mode != 1) ? cur_a : longint'($signed($urandom));
                while (left_a + left_b > 0)
                begin
                    if (left_b == 0 || (left_a != 0 && $urandom_range(0, 1) == 1))
                    begin
                        issue_request(sqm_pkg::OP_PUSH_A, 32'(cur_a));
                        cur_a = next_sorted(cur_a, narrow);
                        left_a--;
                    end
                    else
                    begin
                        issue_request(sqm_pkg::OP_PUSH_B, 32'(cur_b));
                        cur_b = next_sorted(cur_b, narrow);
                        left_b--;
                    end
                end
                issue_request(sqm_pkg::OP_MERGE, $urandom);
                if ($urandom_range(0, 7) == 0)
                    issue_request(sqm_pkg::OP_MERGE, $urandom);
            end
            else if (kind < 92)
            begin
                // noise: unsorted pushes and unused codes
                repeat ($urandom_range(1, 6))
                    issue_request(2'($urandom_range(0, 3)), $urandom);
            end
            else
            begin
                issue_request(sqm_pkg::OP_MERGE, $urandom);
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        // let the last results out, then watch for stray results
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
